// File: rtl/assert_macros.svh
// Assertion shorthands used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RMQ_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants of the matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int ELEM_W = 16;  // width of a matrix element or component
   localparam int MAG_W  = 17;  // magnitude of a sum of two elements

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

   // Control that travels with each item down the pipeline.
   typedef struct packed {
      logic       valid;
      case_type   kase;
      logic       degen;
      logic [2:0] neg;
   } side_type;

endpackage

// File: rtl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_req_if / rmq_rsp_if
// Valid/ready channels for matrices in and quaternions out.
// ----------------------------------------------------------------------------
interface rmq_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface rmq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
   logic [1:0]         case_taken;
   logic               degenerate;

   modport source(output valid, quat_x, quat_y, quat_z, quat_w, case_taken, degenerate,
                  input ready);
   modport sink(input valid, quat_x, quat_y, quat_z, quat_w, case_taken, degenerate,
                output ready);
endinterface

// File: rtl/rotation_matrix_to_quaternion_top.sv
// An input transfer passes the front stage, the square-root cells, the stage between
// the chains, the divider cells and the output register, and waits while the result stalls.
// Throughput: one matrix per cycle; the cell chains advance together, one bit
// per cell, and only stall when the output register holds an untaken result.
// Reset (synchronous, active high) empties every stage at once.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix to unit quaternion by Shepperd's method, fully pipelined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic     clock,
   input  logic     reset,
   rmq_req_if.sink   req_chan,
   rmq_rsp_if.source rsp_chan
);

   // Root argument fits in ARG_W signed bits; the radicand arg * 2^FRAC_BITS
   // is padded to an even width so the root takes exactly ROOT_W cells.
   localparam int ARG_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
   localparam int ROOT_W = (ARG_W + FRAC_BITS) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int DEN_W  = ROOT_W + 2;
   localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
   localparam int PASS_W = 3 * MAG_W;

   // One enable moves the whole pipeline; the output register parts the
   // two sides, so a new transfer is taken whenever that register drains.
   logic en;

   // Front stage.
   side_type               f_side;
   logic [RAD_W-1:0]       f_rad;
   logic [2:0][MAG_W-1:0]  f_mag;

   // Square-root chain taps.
   side_type               sq_side [ROOT_W+1];
   logic [RAD_W-1:0]       sq_rad  [ROOT_W+1];
   logic [ROOT_W+1:0]      sq_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]      sq_root [ROOT_W+1];
   logic [PASS_W-1:0]      sq_pass [ROOT_W+1];

   // Stage between the chains: rounded root, numerators and divisor.
   side_type               p_side_ff;
   logic [DEN_W-1:0]       p_den_ff, p_den_in;
   logic [ELEM_W-1:0]      p_hs_ff, p_hs_in;
   logic [2:0][NUM_W-1:0]  p_num_ff, p_num_in;
   logic [ROOT_W:0]        root_inc;
   logic [ROOT_W-1:0]      h;

   // Divider chain taps.
   side_type               dv_side [NUM_W+1];
   logic [DEN_W-1:0]       dv_den  [NUM_W+1];
   logic [ELEM_W-1:0]      dv_hs   [NUM_W+1];
   logic [2:0][NUM_W-1:0]  dv_num  [NUM_W+1];
   logic [2:0][DEN_W-1:0]  dv_rem  [NUM_W+1];
   logic [2:0][NUM_W-1:0]  dv_quot [NUM_W+1];

   // Output register.
   logic                   o_valid_ff;
   logic [ELEM_W-1:0]      o_x_ff, o_y_ff, o_z_ff, o_w_ff, o_x_in, o_y_in, o_z_in, o_w_in;
   case_type               o_kase_ff;
   logic                   o_degen_ff;
   logic [ELEM_W-1:0]      lane [3];
   side_type               last;

   assign en             = !o_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   rmq_front #(
      .FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W), .RAD_W(RAD_W)
   ) u_front (
      .clock(clock), .reset(reset), .en(en), .valid_i(req_chan.valid),
      .m00(req_chan.m00), .m01(req_chan.m01), .m02(req_chan.m02),
      .m10(req_chan.m10), .m11(req_chan.m11), .m12(req_chan.m12),
      .m20(req_chan.m20), .m21(req_chan.m21), .m22(req_chan.m22),
      .side_o(f_side), .rad_o(f_rad), .mag_o(f_mag)
   );

   assign sq_side[0] = f_side;
   assign sq_rad[0]  = f_rad;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_pass[0] = f_mag;

   // Each square-root cell settles one root bit from the next two radicand bits.
   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      rmq_sqrt_cell #(.ROOT_W(ROOT_W), .PASS_W(PASS_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .side_i(sq_side[g]), .rad_i(sq_rad[g]), .rem_i(sq_rem[g]),
         .root_i(sq_root[g]), .pass_i(sq_pass[g]),
         .side_o(sq_side[g+1]), .rad_o(sq_rad[g+1]), .rem_o(sq_rem[g+1]),
         .root_o(sq_root[g+1]), .pass_o(sq_pass[g+1])
      );
   end

   // h is half the root, rounded to nearest; the divisor S is 4h, and adding 2h
   // to each numerator rounds the quotient to nearest, ties away from zero
   // once the sign is put back.
   always_comb begin
      root_inc = (ROOT_W+1)'(sq_root[ROOT_W]) + (ROOT_W+1)'(1);
      h        = root_inc[ROOT_W:1];
      p_den_in = {h, 2'b00};
      p_hs_in  = ((ROOT_W+1)'(h) > (ROOT_W+1)'(16'h7FFF)) ? 16'h7FFF : ELEM_W'(h);
      for (int i = 0; i < 3; i++) begin
         p_num_in[i] = (NUM_W'(sq_pass[ROOT_W][i*MAG_W +: MAG_W]) << FRAC_BITS)
                     + NUM_W'({h, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_side_ff.valid <= 1'b0;
      end else if (en) begin
         p_side_ff.valid <= sq_side[ROOT_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_side_ff.kase  <= sq_side[ROOT_W].kase;
         p_side_ff.degen <= sq_side[ROOT_W].degen;
         p_side_ff.neg   <= sq_side[ROOT_W].neg;
         p_den_ff        <= p_den_in;
         p_hs_ff         <= p_hs_in;
         p_num_ff        <= p_num_in;
      end
   end

   assign dv_side[0] = p_side_ff;
   assign dv_den[0]  = p_den_ff;
   assign dv_hs[0]   = p_hs_ff;
   assign dv_num[0]  = p_num_ff;
   assign dv_rem[0]  = '0;
   assign dv_quot[0] = '0;

   // Each divider cell produces one quotient bit for all three lanes.
   for (genvar g = 0; g < NUM_W; g++) begin : g_div
      rmq_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .side_i(dv_side[g]), .den_i(dv_den[g]), .hs_i(dv_hs[g]),
         .num_i(dv_num[g]), .rem_i(dv_rem[g]), .quot_i(dv_quot[g]),
         .side_o(dv_side[g+1]), .den_o(dv_den[g+1]), .hs_o(dv_hs[g+1]),
         .num_o(dv_num[g+1]), .rem_o(dv_rem[g+1]), .quot_o(dv_quot[g+1])
      );
   end

   // Restore signs with saturation, then route lanes and h to components.
   always_comb begin
      last = dv_side[NUM_W];
      for (int i = 0; i < 3; i++) begin
         if (last.neg[i]) begin
            if (dv_quot[NUM_W][i] > NUM_W'(32768)) begin
               lane[i] = 16'h8000;
            end else begin
               lane[i] = ELEM_W'(~dv_quot[NUM_W][i] + NUM_W'(1));
            end
         end else begin
            if (dv_quot[NUM_W][i] > NUM_W'(32767)) begin
               lane[i] = 16'h7FFF;
            end else begin
               lane[i] = ELEM_W'(dv_quot[NUM_W][i]);
            end
         end
      end
      unique case (last.kase)
         CASE_TRACE: begin
            o_w_in = dv_hs[NUM_W]; o_x_in = lane[0]; o_y_in = lane[1]; o_z_in = lane[2];
         end
         CASE_X: begin
            o_x_in = dv_hs[NUM_W]; o_w_in = lane[0]; o_y_in = lane[1]; o_z_in = lane[2];
         end
         CASE_Y: begin
            o_y_in = dv_hs[NUM_W]; o_w_in = lane[0]; o_x_in = lane[1]; o_z_in = lane[2];
         end
         default: begin
            o_z_in = dv_hs[NUM_W]; o_w_in = lane[0]; o_x_in = lane[1]; o_y_in = lane[2];
         end
      endcase
      // A non-positive root argument forces every component to zero.
      if (last.degen) begin
         o_x_in = '0; o_y_in = '0; o_z_in = '0; o_w_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_x_ff     <= o_x_in;
         o_y_ff     <= o_y_in;
         o_z_ff     <= o_z_in;
         o_w_ff     <= o_w_in;
         o_kase_ff  <= last.kase;
         o_degen_ff <= last.degen;
      end
   end

   assign rsp_chan.valid      = o_valid_ff;
   assign rsp_chan.quat_x     = o_x_ff;
   assign rsp_chan.quat_y     = o_y_ff;
   assign rsp_chan.quat_z     = o_z_ff;
   assign rsp_chan.quat_w     = o_w_ff;
   assign rsp_chan.case_taken = o_kase_ff;
   assign rsp_chan.degenerate = o_degen_ff;

   // A degenerate result carries all-zero components.
   `RMQ_ASSERT(a_degen_zero, !(o_valid_ff && o_degen_ff) || (o_x_ff == '0 && o_y_ff == '0 && o_z_ff == '0 && o_w_ff == '0), "degenerate result with nonzero components")
   // For a valid root argument in the trace branch, w is strictly positive.
   `RMQ_ASSERT(a_large_pos, !(o_valid_ff && !o_degen_ff && o_kase_ff == CASE_TRACE) || (!o_w_ff[ELEM_W-1] && o_w_ff != '0), "trace branch with non-positive w")
   // A transfer in lands in the front stage on the next edge.
   `RMQ_ASSERT_NEXT(a_front_load, req_chan.valid && req_chan.ready, f_side.valid, "accepted matrix lost at the front stage")
   // A stalled output register keeps its result.
   `RMQ_ASSERT_NEXT(a_hold, o_valid_ff && !en, o_valid_ff && $stable(o_w_ff), "stalled result changed")

endmodule

// File: rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Picks the branch, forms the root argument and the three off-diagonal terms.
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
   parameter int FRAC_BITS = 14,
   parameter int ARG_W     = 19,
   parameter int RAD_W     = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          valid_i,
   input  logic signed [ELEM_W-1:0]      m00, m01, m02, m10, m11, m12, m20, m21, m22,
   output side_type                      side_o,
   output logic [RAD_W-1:0]              rad_o,
   output logic [2:0][MAG_W-1:0]         mag_o
);

   side_type                 side_in, side_ff;
   logic [RAD_W-1:0]         rad_in, rad_ff;
   logic [2:0][MAG_W-1:0]    mag_in, mag_ff;

   logic signed [ARG_W-1:0]  e00, e11, e22, one, tr, arg;
   logic signed [MAG_W-1:0]  ta, tb, tc, tp, tq, tr2;
   logic signed [MAG_W-1:0]  d [3];

   function automatic logic signed [MAG_W-1:0] ext(input logic signed [ELEM_W-1:0] v);
      return MAG_W'(v);
   endfunction

   always_comb begin
      e00 = ARG_W'(m00);
      e11 = ARG_W'(m11);
      e22 = ARG_W'(m22);
      one = ARG_W'(1) <<< FRAC_BITS;
      tr  = e00 + e11 + e22;
      ta  = ext(m21) - ext(m12);
      tb  = ext(m02) - ext(m20);
      tc  = ext(m10) - ext(m01);
      tp  = ext(m01) + ext(m10);
      tq  = ext(m02) + ext(m20);
      tr2 = ext(m12) + ext(m21);
      side_in.valid = valid_i;
      priority if (tr > 0) begin
         side_in.kase = CASE_TRACE;
         arg = tr + one;
         d[0] = ta; d[1] = tb; d[2] = tc;
      end else if (m00 > m11 && m00 > m22) begin
         side_in.kase = CASE_X;
         arg = one + e00 - e11 - e22;
         d[0] = ta; d[1] = tp; d[2] = tq;
      end else if (m11 > m22) begin
         side_in.kase = CASE_Y;
         arg = one + e11 - e00 - e22;
         d[0] = tb; d[1] = tp; d[2] = tr2;
      end else begin
         side_in.kase = CASE_Z;
         arg = one + e22 - e00 - e11;
         d[0] = tc; d[1] = tq; d[2] = tr2;
      end
      side_in.degen = (arg <= 0);
      for (int i = 0; i < 3; i++) begin
         side_in.neg[i] = d[i][MAG_W-1];
         mag_in[i] = d[i][MAG_W-1] ? MAG_W'(-d[i]) : MAG_W'(d[i]);
      end
      rad_in = RAD_W'(arg[ARG_W-2:0]) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.kase  <= side_in.kase;
         side_ff.degen <= side_in.degen;
         side_ff.neg   <= side_in.neg;
         rad_ff        <= rad_in;
         mag_ff        <= mag_in;
      end
   end

   assign side_o = side_ff;
   assign rad_o  = rad_ff;
   assign mag_o  = mag_ff;

endmodule

// File: rtl/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; #(
   parameter int ROOT_W = 16,
   parameter int PASS_W = 51
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  side_type              side_i,
   input  logic [2*ROOT_W-1:0]   rad_i,
   input  logic [ROOT_W+1:0]     rem_i,
   input  logic [ROOT_W-1:0]     root_i,
   input  logic [PASS_W-1:0]     pass_i,
   output side_type              side_o,
   output logic [2*ROOT_W-1:0]   rad_o,
   output logic [ROOT_W+1:0]     rem_o,
   output logic [ROOT_W-1:0]     root_o,
   output logic [PASS_W-1:0]     pass_o
);

   side_type               side_ff;
   logic [2*ROOT_W-1:0]    rad_in, rad_ff;
   logic [ROOT_W+1:0]      rem_in, rem_ff;
   logic [ROOT_W-1:0]      root_in, root_ff;
   logic [PASS_W-1:0]      pass_ff;
   logic [ROOT_W+3:0]      cur, trial;

   always_comb begin
      cur   = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
      trial = (ROOT_W+4)'({root_i, 2'b01});
      rad_in = rad_i << 2;
      if (cur >= trial) begin
         rem_in  = (ROOT_W+2)'(cur - trial);
         root_in = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = cur[ROOT_W+1:0];
         root_in = {root_i[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.kase  <= side_i.kase;
         side_ff.degen <= side_i.degen;
         side_ff.neg   <= side_i.neg;
         rad_ff        <= rad_in;
         rem_ff        <= rem_in;
         root_ff       <= root_in;
         pass_ff       <= pass_i;
      end
   end

   assign side_o = side_ff;
   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign pass_o = pass_ff;

endmodule

// File: rtl/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a restoring divide, for three lanes sharing a divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  side_type                side_i,
   input  logic [DEN_W-1:0]        den_i,
   input  logic [ELEM_W-1:0]       hs_i,
   input  logic [2:0][NUM_W-1:0]   num_i,
   input  logic [2:0][DEN_W-1:0]   rem_i,
   input  logic [2:0][NUM_W-1:0]   quot_i,
   output side_type                side_o,
   output logic [DEN_W-1:0]        den_o,
   output logic [ELEM_W-1:0]       hs_o,
   output logic [2:0][NUM_W-1:0]   num_o,
   output logic [2:0][DEN_W-1:0]   rem_o,
   output logic [2:0][NUM_W-1:0]   quot_o
);

   side_type                side_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [ELEM_W-1:0]       hs_ff;
   logic [2:0][NUM_W-1:0]   num_in, num_ff, quot_in, quot_ff;
   logic [2:0][DEN_W-1:0]   rem_in, rem_ff;
   logic [DEN_W:0]          cur [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cur[i]    = {rem_i[i], num_i[i][NUM_W-1]};
         num_in[i] = num_i[i] << 1;
         if (cur[i] >= {1'b0, den_i}) begin
            rem_in[i]  = DEN_W'(cur[i] - {1'b0, den_i});
            quot_in[i] = {quot_i[i][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = cur[i][DEN_W-1:0];
            quot_in[i] = {quot_i[i][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else if (en) begin
         side_ff.valid <= side_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff.kase  <= side_i.kase;
         side_ff.degen <= side_i.degen;
         side_ff.neg   <= side_i.neg;
         den_ff        <= den_i;
         hs_ff         <= hs_i;
         num_ff        <= num_in;
         rem_ff        <= rem_in;
         quot_ff       <= quot_in;
      end
   end

   assign side_o = side_ff;
   assign den_o  = den_ff;
   assign hs_o   = hs_ff;
   assign num_o  = num_ff;
   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;

endmodule
